### design/mibr_pkg.sv
`timescale 1ns / 1ps

package mibr_pkg;

    // Fixed widths of the request and result fields.
    localparam int FIELD_BITS = 16;

    // Width of a batch tag and of a stored table tag.
    localparam int TAG_BITS = 16;

    // Defaults for the table address width and the local index width.
    localparam int GLOBAL_BITS_DEF = 16;
    localparam int LOCAL_BITS_DEF  = 16;

    // Corners of one triangle.
    localparam int TRI_CORNERS = 3;

    // Reset value of the split threshold.
    localparam logic [FIELD_BITS-1:0] THRESHOLD_RESET = '1;

endpackage

### design/mibr_ifs.sv
`timescale 1ns / 1ps

// Index request channel: one triangle corner per request.
interface mibr_in_if import mibr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] global_index;
    logic                  whole_mesh_fits;
    logic                  last_index;

    modport source (output valid, global_index, whole_mesh_fits, last_index, input ready);
    modport sink   (input valid, global_index, whole_mesh_fits, last_index, output ready);
endinterface

// Result channel: one remapped index per request.
interface mibr_out_if import mibr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] local_index;
    logic                  new_vertex;
    logic [FIELD_BITS-1:0] source_vertex;
    logic                  batch_end;

    modport source (output valid, local_index, new_vertex, source_vertex, batch_end,
                    input ready);
    modport sink   (input valid, local_index, new_vertex, source_vertex, batch_end,
                    output ready);
endinterface

// Configuration write channel for the split threshold.
interface mibr_cfg_if import mibr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] split_threshold;

    modport source (output valid, split_threshold, input ready);
    modport sink   (input valid, split_threshold, output ready);
endinterface

### design/mesh_index_batch_remapper.sv
`timescale 1ns / 1ps
// A request accepted on the index port waits in the lookup stage for its table read,
// then goes to the output register once free. Throughput: one request per
// cycle unless a result stall or a sweep holds the flow, limited by the single remap
// table read port. Reset (rst_n, asynchronous, active low) clears all control state
// and then starts a table clearing pass over every entry, during which no request
// is taken. The pass recurs whenever the batch tag wraps, once every 65535 batches.
module mesh_index_batch_remapper import mibr_pkg::*; #(
    parameter int GLOBAL_BITS = GLOBAL_BITS_DEF,
    parameter int LOCAL_BITS  = LOCAL_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    mibr_cfg_if.sink        cfg,
    mibr_in_if.sink         idx,
    mibr_out_if.source      res
);

    localparam int DEPTH    = 1 << GLOBAL_BITS;
    localparam int ENTRY_W  = TAG_BITS + LOCAL_BITS;
    localparam int LOCAL_CAP = (1 << LOCAL_BITS) - 1;

    // The remap table holds one entry per global index: the batch tag that wrote it
    // in the upper bits and the local index it was given in the lower bits. Tags
    // are cleared by a sweep; local indices are only read behind a matching tag.
    logic [ENTRY_W-1:0] remap_mem [DEPTH];

    // The user writes the threshold only while the block is idle; it is not enforced.
    logic [FIELD_BITS-1:0] split_threshold_reg;

    // Batch state, owned by the lookup stage.
    logic [TAG_BITS-1:0]   batch_tag_reg,   batch_tag_next;
    logic [LOCAL_BITS-1:0] vertex_count_reg, vertex_count_next;
    logic [1:0]            corner_reg,      corner_next;

    // Clearing sweep.
    logic                   clearing_reg, clearing_next;
    logic [GLOBAL_BITS-1:0] clr_addr_reg, clr_addr_next;

    // Lookup stage: the request whose table read is in flight or done.
    logic                   s1_valid_reg, s1_valid_next;
    logic [FIELD_BITS-1:0]  s1_g_reg;
    logic                   s1_fits_reg;
    logic                   s1_last_reg;
    logic                   s1_stale_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;

    // Copy of the last lookup-stage write. A read issued in the same cycle as that
    // write returns the old contents, so the lookup stage takes this copy instead.
    logic                   fwd_valid_reg, fwd_valid_next;
    logic [GLOBAL_BITS-1:0] fwd_addr_reg;
    logic [ENTRY_W-1:0]     fwd_data_reg;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    logic [FIELD_BITS-1:0] out_local_reg;
    logic                  out_new_reg;
    logic [FIELD_BITS-1:0] out_src_reg;
    logic                  out_end_reg;

    // Combinational signals of the lookup stage.
    logic                    in_fire;
    logic                    s1_fire;
    logic [GLOBAL_BITS-1:0]  in_addr;
    logic [GLOBAL_BITS-1:0]  s1_addr;
    logic [ENTRY_W-1:0]      entry;
    logic                    hit;
    logic [FIELD_BITS-1:0]   thr_capped;
    logic [FIELD_BITS-1:0]   split_limit;
    logic [FIELD_BITS-1:0]   res_local;
    logic                    res_new;
    logic [FIELD_BITS-1:0]   res_src;
    logic                    res_end;
    logic                    tbl_wr_en;
    logic [ENTRY_W-1:0]      tbl_wr_data;
    logic                    wrap_start;
    logic                    mem_we;
    logic [GLOBAL_BITS-1:0]  mem_waddr;
    logic [ENTRY_W-1:0]      mem_wdata;

    // The low GLOBAL_BITS bits of the global index address the table; a wider table
    // sees the index zero extended.
    function automatic logic [GLOBAL_BITS-1:0] tbl_addr(input logic [FIELD_BITS-1:0] g);
        logic [GLOBAL_BITS+FIELD_BITS-1:0] g_ext;
        g_ext = {{GLOBAL_BITS{1'b0}}, g};
        return g_ext[GLOBAL_BITS-1:0];
    endfunction

    assign cfg.ready = 1'b1;

    // A new request enters when the lookup stage is empty or hands its request on
    // in this cycle. Nothing enters while the table is being swept.
    assign s1_fire  = s1_valid_reg && !clearing_reg && (!out_valid_reg || res.ready);
    assign idx.ready = !clearing_reg && (!s1_valid_reg || s1_fire);
    assign in_fire  = idx.valid && idx.ready;
    assign in_addr  = tbl_addr(idx.global_index);
    assign s1_addr  = tbl_addr(s1_g_reg);

    // Effective split limit: threshold capped to the local index range, minus one
    // triangle, saturated at zero.
    always_comb
    begin
        if (split_threshold_reg > FIELD_BITS'(LOCAL_CAP))
        begin
            thr_capped = FIELD_BITS'(LOCAL_CAP);
        end
        else
        begin
            thr_capped = split_threshold_reg;
        end
        if (thr_capped >= FIELD_BITS'(TRI_CORNERS))
        begin
            split_limit = thr_capped - FIELD_BITS'(TRI_CORNERS);
        end
        else
        begin
            split_limit = '0;
        end
    end

    // Lookup, allocation and batch bookkeeping.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
        begin
            entry = fwd_data_reg;
        end
        else
        begin
            entry = rd_data_reg;
        end
        // A read taken just before a clearing sweep saw stale tags; after the sweep
        // every tag is zero, so that request is a miss.
        hit = !s1_stale_reg && (entry[ENTRY_W-1:LOCAL_BITS] == batch_tag_reg);

        batch_tag_next    = batch_tag_reg;
        vertex_count_next = vertex_count_reg;
        corner_next       = corner_reg;
        res_local   = '0;
        res_new     = 1'b0;
        res_src     = '0;
        res_end     = 1'b0;
        tbl_wr_en   = 1'b0;
        tbl_wr_data = {batch_tag_reg, vertex_count_reg};
        wrap_start  = 1'b0;

        if (s1_fire)
        begin
            if (s1_fits_reg)
            begin
                // The whole mesh fits in one batch: pass the index through.
                res_local = s1_g_reg;
                res_end   = s1_last_reg;
            end
            else
            begin
                if (hit)
                begin
                    res_local = FIELD_BITS'(entry[LOCAL_BITS-1:0]);
                end
                else
                begin
                    res_local = FIELD_BITS'(vertex_count_reg);
                    res_new   = 1'b1;
                    res_src   = s1_g_reg;
                    tbl_wr_en = 1'b1;
                    if (vertex_count_reg != LOCAL_BITS'(LOCAL_CAP))
                    begin
                        vertex_count_next = vertex_count_reg + 1'b1;
                    end
                end

                // Check the batch size after each completed triangle.
                if (corner_reg == 2'(TRI_CORNERS - 1))
                begin
                    corner_next = '0;
                    if (FIELD_BITS'(vertex_count_next) > split_limit)
                    begin
                        res_end = 1'b1;
                    end
                end
                else
                begin
                    corner_next = corner_reg + 1'b1;
                end
                if (s1_last_reg)
                begin
                    res_end = 1'b1;
                end
            end

            // Closing a batch moves to a new tag, which empties the table logically.
            if (res_end)
            begin
                vertex_count_next = '0;
                corner_next       = '0;
                if (batch_tag_reg == '1)
                begin
                    batch_tag_next = TAG_BITS'(1);
                    wrap_start     = 1'b1;
                end
                else
                begin
                    batch_tag_next = batch_tag_reg + 1'b1;
                end
            end
        end
    end

    // Clearing sweep control and the single table write port.
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end
        else if (wrap_start)
        begin
            clearing_next = 1'b1;
            clr_addr_next = '0;
        end

        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = tbl_wr_en;
            mem_waddr = s1_addr;
            mem_wdata = tbl_wr_data;
        end
    end

    // Stage and output handshake bookkeeping.
    always_comb
    begin
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end

        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        // The forwarded copy goes stale once the sweep starts.
        if (wrap_start || clearing_reg)
        begin
            fwd_valid_next = 1'b0;
        end
        else if (tbl_wr_en)
        begin
            fwd_valid_next = 1'b1;
        end
        else
        begin
            fwd_valid_next = fwd_valid_reg;
        end
    end

    // Table memory: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            remap_mem[mem_waddr] <= mem_wdata;
        end
        if (in_fire)
        begin
            rd_data_reg <= remap_mem[in_addr];
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            split_threshold_reg <= THRESHOLD_RESET;
            batch_tag_reg       <= TAG_BITS'(1);
            vertex_count_reg    <= '0;
            corner_reg          <= '0;
            clearing_reg        <= 1'b1;
            clr_addr_reg        <= '0;
            s1_valid_reg        <= 1'b0;
            fwd_valid_reg       <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                split_threshold_reg <= cfg.split_threshold;
            end
            batch_tag_reg    <= batch_tag_next;
            vertex_count_reg <= vertex_count_next;
            corner_reg       <= corner_next;
            clearing_reg     <= clearing_next;
            clr_addr_reg     <= clr_addr_next;
            s1_valid_reg     <= s1_valid_next;
            fwd_valid_reg    <= fwd_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_g_reg     <= idx.global_index;
            s1_fits_reg  <= idx.whole_mesh_fits;
            s1_last_reg  <= idx.last_index;
            s1_stale_reg <= wrap_start;
        end
        if (tbl_wr_en)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= tbl_wr_data;
        end
        if (s1_fire)
        begin
            out_local_reg <= res_local;
            out_new_reg   <= res_new;
            out_src_reg   <= res_src;
            out_end_reg   <= res_end;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.local_index   = out_local_reg;
    assign res.new_vertex    = out_new_reg;
    assign res.source_vertex = out_src_reg;
    assign res.batch_end     = out_end_reg;

endmodule

### verif/tb_mesh_index_batch_remapper.sv
`timescale 1ns / 1ps

module tb_mesh_index_batch_remapper;
    import mibr_pkg::*;

    // Depth of the remap table and the largest local vertex count that the
    // block can hand out, for the default parameter values.
    localparam int unsigned TABLE_DEPTH = 1 << GLOBAL_BITS_DEF;
    localparam int unsigned LOCAL_LIMIT = (1 << LOCAL_BITS_DEF) - 1;

    // One remapped index as the result channel carries it.
    typedef struct packed {
        logic [FIELD_BITS-1:0] local_index;
        logic                  new_vertex;
        logic [FIELD_BITS-1:0] source_vertex;
        logic                  batch_end;
    } remap_result_t;

    logic clk;
    logic rst_n;

    mibr_cfg_if cfg_bus ();
    mibr_in_if  idx_bus ();
    mibr_out_if res_bus ();

    mesh_index_batch_remapper dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .idx   (idx_bus),
        .res   (res_bus)
    );

    // Shadow copy of the block's state. The table is indexed by global index and
    // holds the local index handed out for it and the batch tag it was written
    // under. An entry only counts as a hit when its tag equals the current one.
    logic [FIELD_BITS-1:0] table_local [TABLE_DEPTH];
    logic [TAG_BITS-1:0]   table_tag [TABLE_DEPTH];
    logic [TAG_BITS-1:0]   cur_batch_tag;
    int unsigned           batch_vertices;
    int unsigned           corner_count;
    int unsigned           split_threshold_setting;

    // Results still owed by the block, oldest first.
    remap_result_t pending_remaps[$];
    int unsigned   mismatch_count;

    // Random gaps on each side can be switched off for the long phases.
    bit sender_idles;
    bit receiver_stalls;

    always #10 clk = ~clk;

    // A closed batch starts over at local index zero with a fresh tag. When the
    // tag runs out, every stored tag goes back to zero so that no old entry can
    // match the restarted tag.
    function automatic void retire_batch();
        batch_vertices = 0;
        corner_count = 0;
        cur_batch_tag = cur_batch_tag + 1'b1;
        if (cur_batch_tag == '0)
        begin
            foreach (table_tag[i])
                table_tag[i] = '0;
            cur_batch_tag = 1;
        end
    endfunction

    // Works out the result of one index request and advances the shadow state.
    function automatic remap_result_t predict_remap(logic [FIELD_BITS-1:0] global_index,
                                                    logic whole_mesh_fits,
                                                    logic last_index);
        remap_result_t r;
        int unsigned   capped;
        int unsigned   split_limit;
        r.local_index = global_index;
        r.new_vertex = 1'b0;
        r.source_vertex = '0;
        r.batch_end = last_index;
        if (!whole_mesh_fits)
        begin
            capped = (split_threshold_setting < LOCAL_LIMIT) ? split_threshold_setting
                                                              : LOCAL_LIMIT;
            split_limit = (capped >= TRI_CORNERS) ? capped - TRI_CORNERS : 0;
            if (table_tag[global_index] == cur_batch_tag)
            begin
                r.local_index = table_local[global_index];
            end
            else
            begin
                // A miss appends the vertex to the batch under the next local index.
                r.local_index = batch_vertices[FIELD_BITS-1:0];
                table_local[global_index] = batch_vertices[FIELD_BITS-1:0];
                table_tag[global_index] = cur_batch_tag;
                if (batch_vertices < LOCAL_LIMIT)
                    batch_vertices++;
                r.new_vertex = 1'b1;
                r.source_vertex = global_index;
            end
            // Splits only happen on triangle boundaries.
            corner_count++;
            if (corner_count >= TRI_CORNERS)
            begin
                corner_count = 0;
                if (batch_vertices > split_limit)
                    r.batch_end = 1'b1;
            end
        end
        if (r.batch_end)
            retire_batch();
        return r;
    endfunction

    // Sends one index request. The valid stays high after acceptance so that a
    // back-to-back request does not lower and raise it in one step; it is only
    // lowered at the start of a gap or when the sender drains.
    task automatic send_index(input logic [FIELD_BITS-1:0] global_index,
                              input logic whole_mesh_fits,
                              input logic last_index);
        int gap;
        gap = sender_idles ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            idx_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        idx_bus.valid <= 1'b1;
        idx_bus.global_index <= global_index;
        idx_bus.whole_mesh_fits <= whole_mesh_fits;
        idx_bus.last_index <= last_index;
        @(posedge clk);
        while (idx_bus.ready !== 1'b1)
            @(posedge clk);
        pending_remaps.push_back(predict_remap(global_index, whole_mesh_fits, last_index));
    endtask

    // Stops sending and waits until every owed result has come back, then gives the
    // two-stage pipeline time to settle.
    task automatic drain_results();
        idx_bus.valid <= 1'b0;
        while (pending_remaps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the split threshold. Only called while the block is idle.
    task automatic write_threshold(input logic [FIELD_BITS-1:0] threshold);
        cfg_bus.valid <= 1'b1;
        cfg_bus.split_threshold <= threshold;
        @(posedge clk);
        while (cfg_bus.ready !== 1'b1)
            @(posedge clk);
        cfg_bus.valid <= 1'b0;
        split_threshold_setting = threshold;
    endtask

    // Hand-picked requests: field extremes, hits and misses, pass-through with
    // and without the last flag, a mesh that ends in the middle of a triangle,
    // an entry from an older batch that must not hit, and the smallest threshold.
    task automatic test_directed();
        // Reset threshold: no split can happen in these few requests.
        send_index(16'h0000, 1'b0, 1'b0);
        send_index(16'hFFFF, 1'b0, 1'b0);
        send_index(16'h0000, 1'b0, 1'b0);
        send_index(16'h5555, 1'b1, 1'b0);
        send_index(16'hAAAA, 1'b0, 1'b0);
        // Last index on the second corner of a triangle closes the batch.
        send_index(16'hFFFF, 1'b0, 1'b1);
        // Written in the previous batch, so this is a miss again.
        send_index(16'hFFFF, 1'b0, 1'b0);
        send_index(16'h1234, 1'b1, 1'b1);
        send_index(16'h8001, 1'b1, 1'b0);
        drain_results();

        // Smallest legal threshold: a batch closes at a triangle end once it holds four vertices or more.
        write_threshold(16'd6);
        send_index(16'd10, 1'b0, 1'b0);
        send_index(16'd11, 1'b0, 1'b0);
        send_index(16'd12, 1'b0, 1'b0);
        send_index(16'd13, 1'b0, 1'b0);
        send_index(16'd10, 1'b0, 1'b0);
        send_index(16'd14, 1'b0, 1'b0);
        send_index(16'd10, 1'b0, 1'b0);
        send_index(16'd10, 1'b0, 1'b0);
        send_index(16'd11, 1'b0, 1'b0);
        send_index(16'd12, 1'b0, 1'b0);
        send_index(16'd11, 1'b0, 1'b0);
        send_index(16'd10, 1'b0, 1'b1);
        drain_results();
    endtask

    // One long batch, filled back to back with distinct vertices until it
    // splits on the last triangle. Multiplying by an odd constant visits
    // distinct global indices spread over the range.
    task automatic test_full_batch();
        int unsigned k;
        write_threshold(16'd300);
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
        for (k = 0; k < 300; k++)
            send_index(16'((k * 40503) & 16'hFFFF), 1'b0, 1'b0);
        drain_results();
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // Random meshes: triangles drawn from a small vertex pool so that hits are
    // common, with pass-through meshes, meshes cut short mid-triangle and some
    // stray requests mixed in. Each phase runs under its own threshold.
    task automatic test_random_meshes();
        int unsigned        phase;
        int unsigned        sent;
        int unsigned        pool;
        int unsigned        corners;
        int unsigned        k;
        logic [FIELD_BITS-1:0] base;
        logic [FIELD_BITS-1:0] threshold;
        logic               pass_through;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: threshold = 16'd6;
                1: threshold = 16'd7;
                2: threshold = 16'($urandom_range(8, 24));
                3: threshold = 16'($urandom_range(25, 120));
                4: threshold = THRESHOLD_RESET;
                default: threshold = 16'($urandom_range(6, 65535));
            endcase
            drain_results();
            write_threshold(threshold);
            sent = 0;
            while (sent < 250)
            begin
                // Some meshes run with no gaps on one or both sides.
                sender_idles = ($urandom_range(0, 3) != 0);
                receiver_stalls = ($urandom_range(0, 3) != 0);
                base = 16'($urandom);
                pool = $urandom_range(3, 48);
                pass_through = ($urandom_range(0, 7) == 0);
                corners = 3 * $urandom_range(1, 30);
                if ($urandom_range(0, 9) == 0)
                    corners = corners - $urandom_range(1, 2);
                for (k = 0; k < corners; k++)
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_index(16'($urandom), 1'($urandom_range(0, 1)),
                                   ($urandom_range(0, 15) == 0));
                    else
                        send_index(base + 16'($urandom_range(0, pool - 1)), pass_through,
                                   (k == corners - 1));
                    sent++;
                end
                // Now and then the sender holds off until everything is back.
                if ($urandom_range(0, 15) == 0)
                    drain_results();
            end
        end
        drain_results();
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // Result side: draws a stall before each result, then takes the result and
    // compares it field by field with the oldest owed result.
    initial
    begin : result_checker
        int            stall;
        remap_result_t want;
        res_bus.ready = 1'b0;
        forever
        begin
            stall = receiver_stalls ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (res_bus.valid !== 1'b1)
                @(posedge clk);
            if (pending_remaps.size() == 0)
            begin
                $error("result with no pending request: local_index %0d",
                       res_bus.local_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_remaps.pop_front();
                if (res_bus.local_index !== want.local_index)
                begin
                    $error("local_index: expected %0d, got %0d",
                           want.local_index, res_bus.local_index);
                    mismatch_count++;
                end
                if (res_bus.new_vertex !== want.new_vertex)
                begin
                    $error("new_vertex: expected %0d, got %0d",
                           want.new_vertex, res_bus.new_vertex);
                    mismatch_count++;
                end
                if (res_bus.source_vertex !== want.source_vertex)
                begin
                    $error("source_vertex: expected %0d, got %0d",
                           want.source_vertex, res_bus.source_vertex);
                    mismatch_count++;
                end
                if (res_bus.batch_end !== want.batch_end)
                begin
                    $error("batch_end: expected %0d, got %0d",
                           want.batch_end, res_bus.batch_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence. The shadow state starts as the block comes out of reset;
    // the first requests wait out the table clearing pass through the handshake.
    initial
    begin : main_sequence
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.split_threshold = '0;
        idx_bus.valid = 1'b0;
        idx_bus.global_index = '0;
        idx_bus.whole_mesh_fits = 1'b0;
        idx_bus.last_index = 1'b0;
        sender_idles = 1'b1;
        receiver_stalls = 1'b1;
        mismatch_count = 0;
        foreach (table_tag[i])
        begin
            table_tag[i] = '0;
            table_local[i] = '0;
        end
        cur_batch_tag = 1;
        batch_vertices = 0;
        corner_count = 0;
        split_threshold_setting = THRESHOLD_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_batch();
        test_random_meshes();
        drain_results();

        if (mismatch_count == 0)
            $display("mesh_index_batch_remapper regression: pass");
        else
            $display("mesh_index_batch_remapper regression: fail");
        $finish;
    end

    // Covers the table clearing pass after reset, the long batch and the random
    // phases with their worst gaps, many times over.
    initial
    begin : run_limit
        #30_000_000;
        $display("mesh_index_batch_remapper regression: fail");
        $finish;
    end

endmodule

### sim.f
design/mibr_pkg.sv
design/mibr_ifs.sv
design/mesh_index_batch_remapper.sv
verif/tb_mesh_index_batch_remapper.sv
